// ----- src/nwsp_pkg.sv -----
// Shared types, constants and helper functions of the wind sentence parser.
package nwsp_pkg;

  localparam int FIELD_CHARS     = 6;
  localparam int FRACTION_DIGITS = 3;

  // ASCII codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_R = 8'h52;
  localparam logic [7:0] CH_UPPER_V = 8'h56;

  localparam logic [7:0] OFFSET_RESET = 8'd180;
  localparam int OUT_W = 13;

  // field scaling
  localparam logic [63:0] SCALE      = 64'(10 ** FRACTION_DIGITS);
  localparam logic [63:0] ANGLE_CAP  = 64'd360 * SCALE;
  localparam logic [63:0] SPEED_CAP  = 64'd1000 * SCALE;
  localparam logic [63:0] HALF_TURN  = 64'd180 * SCALE;
  localparam int VAL_W  = $clog2(SPEED_CAP + 64'd1);
  localparam int VALX_W = VAL_W + 4;
  localparam int CW     = VAL_W + 2;
  localparam int CABS_W = $clog2(HALF_TURN + 64'd1);

  localparam logic [VAL_W-1:0]  ANGLE_CAP_C = VAL_W'(ANGLE_CAP);
  localparam logic [VAL_W-1:0]  SPEED_CAP_C = VAL_W'(SPEED_CAP);
  localparam logic [VALX_W-1:0] SCALE_X     = VALX_W'(SCALE);
  localparam logic [2:0]        FD_C        = 3'(FRACTION_DIGITS);
  localparam logic [3:0]        CHARS_C     = 4'(FIELD_CHARS);
  localparam logic signed [CW-1:0] HALF_C   = CW'(HALF_TURN);
  localparam logic signed [CW-1:0] TURN_C   = CW'(64'd2 * HALF_TURN);

  // milliradians per degree in Q36, pi truncated from Q60
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam int          Q_SH    = 36;
  localparam logic [63:0] K_MRAD  = ((PI_Q60 >> 24) * 64'd1000) / 64'd180;
  localparam int          K_W     = $clog2(K_MRAD + 64'd1);
  localparam int          K_SPLIT = 20;
  localparam int          KHI_W   = K_W - K_SPLIT;
  localparam logic [KHI_W-1:0]   K_HI_C = KHI_W'(K_MRAD >> K_SPLIT);
  localparam logic [K_SPLIT-1:0] K_LO_C = K_SPLIT'(K_MRAD);
  localparam int PAHI_W = CABS_W + KHI_W;
  localparam int PALO_W = CABS_W + K_SPLIT;
  localparam int MAG_W  = CABS_W + K_W + 1;

  // angle rounding divide by SCALE through a reciprocal
  localparam logic [63:0] Q_MAX   = (HALF_TURN * K_MRAD) >> Q_SH;
  localparam logic [63:0] X_MAX   = Q_MAX + SCALE / 64'd2;
  localparam int          X_W     = $clog2(X_MAX + 64'd1);
  localparam int          ANG_SH  = X_W + $clog2(SCALE);
  localparam logic [63:0] ANG_M   = ((64'd1 << ANG_SH) + SCALE - 64'd1) / SCALE;
  localparam int          ANG_M_W = $clog2(ANG_M + 64'd1);
  localparam int          ANG_P_W = ANG_SH + OUT_W;
  localparam logic [ANG_M_W-1:0] ANG_M_C    = ANG_M_W'(ANG_M);
  localparam logic [X_W-1:0]     HALF_SCALE = X_W'(SCALE / 64'd2);

  // knots to dm/s
  localparam logic [63:0] KNOT_NUM = 64'd5144444;
  localparam int          KNOT_W   = $clog2(KNOT_NUM + 64'd1);
  localparam logic [63:0] SPD_DEN  = SCALE * 64'd1000000;
  localparam logic [63:0] W_MAX    = SPEED_CAP * KNOT_NUM + SPD_DEN / 64'd2;
  localparam int          W_W      = $clog2(W_MAX + 64'd1);
  localparam int          SPD_SH   = $clog2(SPD_DEN) - 10;
  localparam int          WH_W     = W_W - SPD_SH;
  localparam logic [63:0] SPD_M    = (64'd1 << (32 + SPD_SH)) / SPD_DEN;
  localparam int          SPD_M_W  = $clog2(SPD_M + 64'd1);
  localparam int          SPD_P_W  = 32 + OUT_W;
  localparam logic [KNOT_W-1:0]  KNOT_C     = KNOT_W'(KNOT_NUM);
  localparam logic [W_W-1:0]     SPD_DEN_C  = W_W'(SPD_DEN);
  localparam logic [W_W-1:0]     HALF_DEN_C = W_W'(SPD_DEN / 64'd2);
  localparam logic [SPD_M_W-1:0] SPD_M_C    = SPD_M_W'(SPD_M);

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_CAPTURE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [VAL_W-1:0] value;
    logic [3:0]       count;
    logic [2:0]       frac;
  } field_t;

  // snapshot of one finished sentence handed to the converter
  typedef struct packed {
    logic              c_neg;
    logic [CABS_W-1:0] c_abs;
    logic [VAL_W-1:0]  speed;
  } meas_t;

  function automatic logic [13:0] pw10(input logic [2:0] n);
    logic [13:0] p;
    unique case (n)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

endpackage

// ----- src/nwsp_parser.sv -----
// Byte parser: running checksum, field capture and the sentence snapshot.
module nwsp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  output logic                fire,
  output nwsp_pkg::meas_t     meas
);

  logic            in_sentence, in_sentence_next;
  logic [7:0]      xor_sum, xor_sum_next;
  logic            star_seen, star_seen_next;
  logic [1:0]      check_count, check_count_next;
  logic [7:0]      received_check, received_check_next;
  logic [7:0]      previous_byte, previous_byte_next;
  nwsp_pkg::field_t angle, angle_next;
  nwsp_pkg::field_t speed, speed_next;
  logic [7:0]      offset;
  logic signed [nwsp_pkg::CW-1:0] c_raw, c_wrap;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] h;
    h = 4'd0;
    if (b >= nwsp_pkg::CH_ZERO && b <= nwsp_pkg::CH_NINE) h = b[3:0];
    else if (b >= nwsp_pkg::CH_UPPER_A && b <= nwsp_pkg::CH_UPPER_F) h = b[3:0] + 4'd9;
    return h;
  endfunction

  function automatic nwsp_pkg::field_t field_step(input nwsp_pkg::field_t f,
                                                  input logic [7:0] b,
                                                  input logic [nwsp_pkg::VAL_W-1:0] cap);
    nwsp_pkg::field_t n;
    logic [nwsp_pkg::VALX_W-1:0] v;
    logic take;
    n = f;
    v = nwsp_pkg::VALX_W'(f.value);
    take = 1'b0;
    if (f.phase == nwsp_pkg::PH_CAPTURE) begin
      if (b == nwsp_pkg::CH_COMMA) begin
        n.phase = nwsp_pkg::PH_DONE;
      end else if (b >= nwsp_pkg::CH_ZERO && b <= nwsp_pkg::CH_NINE) begin
        take = 1'b1;
        if (f.frac == 3'd0) begin
          v = v * nwsp_pkg::VALX_W'(10) + nwsp_pkg::VALX_W'(b[3:0]) * nwsp_pkg::SCALE_X;
        end else if (f.frac - 3'd1 < nwsp_pkg::FD_C) begin
          v = v + nwsp_pkg::VALX_W'(b[3:0])
                * nwsp_pkg::VALX_W'(nwsp_pkg::pw10(nwsp_pkg::FD_C - f.frac));
          n.frac = f.frac + 3'd1;
        end
        if (v > nwsp_pkg::VALX_W'(cap)) v = nwsp_pkg::VALX_W'(cap);
      end else if (b == nwsp_pkg::CH_POINT && f.frac == 3'd0) begin
        take = 1'b1;
        n.frac = 3'd1;
      end else begin
        n.phase = nwsp_pkg::PH_DONE;
      end
      if (take) begin
        n.value = v[nwsp_pkg::VAL_W-1:0];
        n.count = f.count + 4'd1;
        if (n.count >= nwsp_pkg::CHARS_C) n.phase = nwsp_pkg::PH_DONE;
      end
    end
    return n;
  endfunction

  // a '$' closes a sentence; it reports only with a matching checksum
  assign fire = (rx_byte == nwsp_pkg::CH_DOLLAR) && in_sentence && star_seen
                && (received_check == xor_sum);

  always_comb begin
    c_raw = $signed(nwsp_pkg::CW'(angle.value))
          + $signed(nwsp_pkg::CW'(64'(offset) * nwsp_pkg::SCALE))
          - nwsp_pkg::HALF_C;
    c_wrap = (c_raw > nwsp_pkg::HALF_C) ? c_raw - nwsp_pkg::TURN_C : c_raw;
    meas.c_neg = c_wrap[nwsp_pkg::CW-1];
    meas.c_abs = nwsp_pkg::CABS_W'(c_wrap[nwsp_pkg::CW-1] ? -c_wrap : c_wrap);
    meas.speed = speed.value;
  end

  always_comb begin
    in_sentence_next    = in_sentence;
    xor_sum_next        = xor_sum;
    star_seen_next      = star_seen;
    check_count_next    = check_count;
    received_check_next = received_check;
    previous_byte_next  = previous_byte;
    angle_next          = angle;
    speed_next          = speed;
    if (rx_byte == nwsp_pkg::CH_DOLLAR) begin
      in_sentence_next    = 1'b1;
      xor_sum_next        = 8'd0;
      star_seen_next      = 1'b0;
      check_count_next    = 2'd0;
      received_check_next = 8'd0;
      previous_byte_next  = nwsp_pkg::CH_DOLLAR;
      angle_next          = '0;
      speed_next          = '0;
    end else if (in_sentence) begin
      if (!star_seen) begin
        if (rx_byte == nwsp_pkg::CH_STAR) star_seen_next = 1'b1;
        else xor_sum_next = xor_sum ^ rx_byte;
      end else if (check_count < 2'd2) begin
        if (check_count == 2'd0) received_check_next = {hex_value(rx_byte), received_check[3:0]};
        else received_check_next = {received_check[7:4], hex_value(rx_byte)};
        check_count_next = check_count + 2'd1;
      end
      angle_next = field_step(angle, rx_byte, nwsp_pkg::ANGLE_CAP_C);
      speed_next = field_step(speed, rx_byte, nwsp_pkg::SPEED_CAP_C);
      // open a field on the first "V," or "R,"
      if (rx_byte == nwsp_pkg::CH_COMMA) begin
        if (angle.phase == nwsp_pkg::PH_SEEK && previous_byte == nwsp_pkg::CH_UPPER_V)
          angle_next.phase = nwsp_pkg::PH_CAPTURE;
        if (speed.phase == nwsp_pkg::PH_SEEK && previous_byte == nwsp_pkg::CH_UPPER_R)
          speed_next.phase = nwsp_pkg::PH_CAPTURE;
      end
      previous_byte_next = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence    <= 1'b0;
      xor_sum        <= 8'd0;
      star_seen      <= 1'b0;
      check_count    <= 2'd0;
      received_check <= 8'd0;
      previous_byte  <= 8'd0;
      angle          <= '0;
      speed          <= '0;
    end else if (accept) begin
      in_sentence    <= in_sentence_next;
      xor_sum        <= xor_sum_next;
      star_seen      <= star_seen_next;
      check_count    <= check_count_next;
      received_check <= received_check_next;
      previous_byte  <= previous_byte_next;
      angle          <= angle_next;
      speed          <= speed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= nwsp_pkg::OFFSET_RESET;
    end else if (cfg_write) begin
      offset <= cfg_data;
    end
  end

endmodule

// ----- src/nwsp_convert.sv -----
// Unit conversion pipeline: angle to milliradians, knots to dm/s, with rounding.
module nwsp_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  nwsp_pkg::meas_t               meas,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [nwsp_pkg::OUT_W-1:0] direction_mrad,
  output logic        [nwsp_pkg::OUT_W-1:0] speed_dmps
);

  // stage 1: snapshot
  logic                          v1, neg1;
  logic [nwsp_pkg::CABS_W-1:0]   c_abs1;
  logic [nwsp_pkg::VAL_W-1:0]    spd1;
  // stage 2: products
  logic                          v2, neg2;
  logic [nwsp_pkg::PAHI_W-1:0]   pa_hi2;
  logic [nwsp_pkg::PALO_W-1:0]   pa_lo2;
  logic [nwsp_pkg::W_W-1:0]      w2;
  // stage 3: rounded quotients before the final divide
  logic                          v3, neg3;
  logic [nwsp_pkg::X_W-1:0]      xa3;
  logic [nwsp_pkg::OUT_W-1:0]    est3;
  logic [nwsp_pkg::W_W-1:0]      w3;

  logic rdy1, rdy2, rdy3, rdy_out;
  logic [nwsp_pkg::PAHI_W-1:0]  pa_hi;
  logic [nwsp_pkg::PALO_W-1:0]  pa_lo;
  logic [nwsp_pkg::W_W-1:0]     w;
  logic [nwsp_pkg::MAG_W-1:0]   mag;
  logic [nwsp_pkg::X_W-1:0]     xa;
  logic [nwsp_pkg::WH_W-1:0]    wh;
  logic [nwsp_pkg::SPD_P_W-1:0] est_prod;
  logic [nwsp_pkg::ANG_P_W-1:0] ang_prod;
  logic [nwsp_pkg::OUT_W-1:0]   mrad;
  logic [nwsp_pkg::W_W-1:0]     back_prod, rem;
  logic [nwsp_pkg::OUT_W-1:0]   spd;

  // each stage fills whenever it is empty or moving on
  assign rdy_out  = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy_out;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    pa_hi = nwsp_pkg::PAHI_W'(c_abs1) * nwsp_pkg::PAHI_W'(nwsp_pkg::K_HI_C);
    pa_lo = nwsp_pkg::PALO_W'(c_abs1) * nwsp_pkg::PALO_W'(nwsp_pkg::K_LO_C);
    w     = nwsp_pkg::W_W'(spd1) * nwsp_pkg::W_W'(nwsp_pkg::KNOT_C) + nwsp_pkg::HALF_DEN_C;
  end

  always_comb begin
    mag = (nwsp_pkg::MAG_W'(pa_hi2) << nwsp_pkg::K_SPLIT) + nwsp_pkg::MAG_W'(pa_lo2);
    xa  = nwsp_pkg::X_W'(mag >> nwsp_pkg::Q_SH) + nwsp_pkg::HALF_SCALE;
    // low estimate of the speed quotient, short by at most one
    wh       = w2[nwsp_pkg::W_W-1:nwsp_pkg::SPD_SH];
    est_prod = nwsp_pkg::SPD_P_W'(wh) * nwsp_pkg::SPD_P_W'(nwsp_pkg::SPD_M_C);
  end

  always_comb begin
    ang_prod  = nwsp_pkg::ANG_P_W'(xa3) * nwsp_pkg::ANG_P_W'(nwsp_pkg::ANG_M_C);
    mrad      = ang_prod[nwsp_pkg::ANG_SH +: nwsp_pkg::OUT_W];
    back_prod = nwsp_pkg::W_W'(est3) * nwsp_pkg::SPD_DEN_C;
    rem       = w3 - back_prod;
    spd       = est3 + nwsp_pkg::OUT_W'(rem >= nwsp_pkg::SPD_DEN_C);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy_out) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      neg1   <= meas.c_neg;
      c_abs1 <= meas.c_abs;
      spd1   <= meas.speed;
    end
    if (rdy2 && v1) begin
      neg2   <= neg1;
      pa_hi2 <= pa_hi;
      pa_lo2 <= pa_lo;
      w2     <= w;
    end
    if (rdy3 && v2) begin
      neg3 <= neg2;
      xa3  <= xa;
      est3 <= est_prod[32 +: nwsp_pkg::OUT_W];
      w3   <= w2;
    end
    if (rdy_out && v3) begin
      direction_mrad <= neg3 ? -$signed(mrad) : $signed(mrad);
      speed_dmps     <= spd;
    end
  end

endmodule

// ----- src/nmea_wind_sentence_parser_top.sv -----
// Top level of the wind sentence parser: byte parser and conversion pipeline.
// Takes one byte per cycle while in_ready is high; in_ready drops only while all
// four result stages are full. The edge that accepts the closing '$' loads the snapshot.
// Result stages: snapshot, partial products, reciprocal estimates, output register.
// Synchronous reset clears the parser state, sets the offset to 180 degrees and
// empties the result pipeline.
module nmea_wind_sentence_parser_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [nwsp_pkg::OUT_W-1:0] direction_mrad,
  output logic        [nwsp_pkg::OUT_W-1:0] speed_dmps,
  input  logic                              cfg_write,
  input  logic [7:0]                        cfg_data
);

  logic            accept;
  logic            fire;
  nwsp_pkg::meas_t meas;

  assign accept = in_valid && in_ready;

  nwsp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .meas      (meas)
  );

  nwsp_convert u_convert (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid && fire),
    .in_ready       (in_ready),
    .meas           (meas),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .direction_mrad (direction_mrad),
    .speed_dmps     (speed_dmps)
  );

endmodule

// ----- src/nwsp_checker.sv -----
// Port-level checks of the wind sentence parser, bound to the top level.
module nwsp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [nwsp_pkg::OUT_W-1:0] direction_mrad,
  input logic        [nwsp_pkg::OUT_W-1:0] speed_dmps
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(direction_mrad) && $stable(speed_dmps))
    else $error("stalled result word changed");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> direction_mrad >= -13'sd3142 && direction_mrad <= 13'sd3142
                  && speed_dmps <= 13'd5145)
    else $error("result word out of range");

  // input backpressure only comes from a blocked output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind nmea_wind_sentence_parser_top nwsp_checker u_nwsp_checker (.*);

// ----- tb/tb_nmea_wind_sentence_parser_top.sv -----
`timescale 1ns / 1ps
// Testbench for the wind sentence parser: byte stream stimulus checked against a local predictor.
module tb_nmea_wind_sentence_parser_top;
  import nwsp_pkg::*;

  localparam int unsigned FRAC_DIGITS = FRACTION_DIGITS;
  localparam int unsigned MAX_CHARS   = FIELD_CHARS;
  localparam int unsigned UNIT        = 10 ** FRACTION_DIGITS;
  localparam int unsigned ANGLE_SAT   = 360 * UNIT;
  localparam int unsigned SPEED_SAT   = 1000 * UNIT;
  localparam longint      HALF_UNITS  = 180 * longint'(UNIT);
  localparam logic [63:0] PI_FIX60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] MRAD_Q36    = (PI_FIX60 >> 24) * 64'd1000 / 64'd180;
  localparam logic [63:0] KNOT_NUMER  = 64'd5144444;
  localparam logic [63:0] KNOT_DENOM  = 64'(UNIT) * 64'd1000000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_PAD    = 8;
  localparam int RANDOM_BYTES = 450;

  typedef enum int {
    SUM_GOOD,
    SUM_WRONG,
    SUM_NONE,
    SUM_LOWER,
    SUM_SHORT,
    SUM_BADHEX
  } sum_form_t;

  typedef struct packed {
    phase_t      phase;
    logic [19:0] value;
    logic [3:0]  count;
    logic [2:0]  frac;
  } field_track_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dir;
    logic        [OUT_W-1:0] spd;
  } wind_reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] direction_mrad;
  logic [OUT_W-1:0] speed_dmps;
  logic cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  nmea_wind_sentence_parser_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .direction_mrad (direction_mrad),
    .speed_dmps     (speed_dmps),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic open_sentence, past_star;
  logic [1:0] check_digits;
  logic [7:0] running_xor, sent_check, last_byte, offset_deg;
  field_track_t angle_trk, speed_trk;
  wind_reading_t expected_readings[$];

  logic [7:0] frame[$];
  int burst_left = 0;
  int bytes_sent = 0;
  int failures = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  logic [31:0] rx_tick = 0;
  int unsigned cycles = 0;

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR: %s", msg);
  endtask

  function automatic field_track_t advance_field(field_track_t f, logic [7:0] b,
                                                 int unsigned cap);
    int unsigned v, fr, cnt, d;
    v = f.value;
    fr = f.frac;
    cnt = f.count;
    if (f.phase != PH_CAPTURE) return f;
    if (b == CH_COMMA) begin
      f.phase = PH_DONE;
      return f;
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = 32'(b - CH_ZERO);
      if (fr == 0) begin
        v = v * 10 + d * UNIT;
      end else if (fr <= FRAC_DIGITS) begin
        v = v + d * 10 ** (FRAC_DIGITS - fr);
        fr++;
      end
      if (v > cap) v = cap;
    end else if (b == CH_POINT && fr == 0) begin
      fr = 1;
    end else begin
      f.phase = PH_DONE;
      return f;
    end
    cnt++;
    if (cnt >= MAX_CHARS) f.phase = PH_DONE;
    f.value = v[19:0];
    f.count = cnt[3:0];
    f.frac = fr[2:0];
    return f;
  endfunction

  task automatic clear_sentence();
    open_sentence = 1'b0;
    past_star = 1'b0;
    check_digits = 2'd0;
    running_xor = 8'd0;
    sent_check = 8'd0;
    last_byte = 8'd0;
    angle_trk = '0;
    speed_trk = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    longint c;
    logic [63:0] mag, mrad, spd;
    logic [3:0] nib;
    wind_reading_t r;
    if (b == CH_DOLLAR) begin
      if (open_sentence && past_star && sent_check == running_xor) begin
        c = longint'(angle_trk.value) + longint'(offset_deg) * longint'(UNIT) - HALF_UNITS;
        // wrap once into the half turn
        if (c > HALF_UNITS) c = c - 2 * HALF_UNITS;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        mag = mag * MRAD_Q36;
        mrad = (mag + (64'(UNIT) << 35)) / (64'(UNIT) << 36);
        r.dir = OUT_W'(mrad);
        if (c < 0) r.dir = -r.dir;
        spd = (64'(speed_trk.value) * KNOT_NUMER + KNOT_DENOM / 2) / KNOT_DENOM;
        r.spd = OUT_W'(spd);
        expected_readings.push_back(r);
      end
      clear_sentence();
      open_sentence = 1'b1;
      last_byte = CH_DOLLAR;
    end else if (open_sentence) begin
      if (!past_star) begin
        if (b == CH_STAR) past_star = 1'b1;
        else running_xor = running_xor ^ b;
      end else if (check_digits < 2'd2) begin
        if (b >= CH_ZERO && b <= CH_NINE) nib = 4'(b - CH_ZERO);
        else if (b >= CH_UPPER_A && b <= CH_UPPER_F) nib = 4'(b - CH_UPPER_A + 8'd10);
        else nib = 4'd0;
        if (check_digits == 2'd0) sent_check[7:4] = nib;
        else sent_check[3:0] = nib;
        check_digits++;
      end
      angle_trk = advance_field(angle_trk, b, ANGLE_SAT);
      speed_trk = advance_field(speed_trk, b, SPEED_SAT);
      if (b == CH_COMMA) begin
        if (angle_trk.phase == PH_SEEK && last_byte == CH_UPPER_V) angle_trk.phase = PH_CAPTURE;
        if (speed_trk.phase == PH_SEEK && last_byte == CH_UPPER_R) speed_trk.phase = PH_CAPTURE;
      end
      last_byte = b;
    end
  endtask

  // sender: bursts of random length with random gaps in between
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk); while (!in_ready);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i]);
    frame.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endtask

  task automatic add_number(input int max_int);
    int n;
    if ($urandom_range(0, 19) == 0) frame.push_back("-");
    n = $urandom_range(0, max_int);
    repeat (n) frame.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 9) < 7) begin
      frame.push_back(CH_POINT);
      n = $urandom_range(0, 4);
      repeat (n) frame.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  function automatic logic [7:0] hex_digit(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'(CH_ZERO + n);
    return 8'((lower ? "a" : CH_UPPER_A) + n - 4'd10);
  endfunction

  // append the checksum part; the sum covers the bytes after the leading '$' up to the first '*'
  task automatic add_check(input sum_form_t form);
    logic [7:0] x;
    logic [3:0] hi, lo;
    x = 8'd0;
    for (int i = 1; i < frame.size() && frame[i] != CH_STAR; i++) x = x ^ frame[i];
    hi = x[7:4];
    lo = x[3:0];
    if (form != SUM_NONE) begin
      frame.push_back(CH_STAR);
      if (form == SUM_WRONG) lo = lo ^ (4'd1 << $urandom_range(0, 3));
      frame.push_back(form == SUM_BADHEX ? "G" : hex_digit(hi, form == SUM_LOWER));
      if (form != SUM_SHORT) frame.push_back(hex_digit(lo, form == SUM_LOWER));
    end
  endtask

  task automatic sentence(input string body, input sum_form_t form);
    add_text(body);
    add_check(form);
    send_frame();
  endtask

  // drop valid, wait for every reading, then let the pipeline settle
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_offset(input logic [7:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
    offset_deg = v;
  endtask

  task automatic test_preamble_and_defaults();
    // no '$' yet: all of this is dropped
    add_text("V,123.4,R,45*00,");
    send_frame();
    sentence("$WIMWV,045.5,R,010.0,N,A", SUM_GOOD);
    sentence("$WIMWV,,R,,N,A", SUM_GOOD);
    sentence("$WIMWV,0,R,0,N,A", SUM_GOOD);
    send_byte(CH_DOLLAR);
    quiesce();
  endtask

  task automatic test_checksum_rules();
    sentence("$WIMWV,090.0,R,5.0,N,A", SUM_WRONG);
    sentence("$WIMWV,090.0,R,5.0,N,A", SUM_NONE);
    sentence("$WIMWV,270.0,R,7.5,N,A", SUM_LOWER);
    sentence("$J,V,30", SUM_LOWER);
    sentence("$@", SUM_SHORT);
    sentence("$@V,10", SUM_SHORT);
    sentence("$AB", SUM_BADHEX);
    sentence("$0", SUM_BADHEX);
    // star with both check digits missing
    add_text("$*");
    send_frame();
    send_byte(CH_DOLLAR);
    quiesce();
  endtask

  task automatic test_field_syntax();
    sentence("$WIMWV,12.34567,R,1.99999,N,A", SUM_GOOD);
    sentence("$WIMWV,-5,R, 7,N,A", SUM_GOOD);
    sentence("$WIMWV,1.2.3,R,4..5,N,A", SUM_GOOD);
    sentence("$WIMWV,999,R,99999,N,A", SUM_GOOD);
    sentence("$WIMWV,359.999,R,1000.0,N,A", SUM_GOOD);
    sentence("$WIMWV,NONE", SUM_GOOD);
    sentence("$V,V,8,R,R,2", SUM_GOOD);
    // marker found only after the check digits
    add_text("$X");
    add_check(SUM_GOOD);
    add_text("R,25");
    send_frame();
    send_byte(CH_DOLLAR);
    quiesce();
  endtask

  task automatic test_offset_extremes();
    logic [7:0] offsets[4];
    offsets = '{8'd0, 8'd255, 8'd90, OFFSET_RESET};
    foreach (offsets[k]) begin
      write_offset(offsets[k]);
      sentence("$V,0,R,0", SUM_GOOD);
      sentence("$V,180,R,1", SUM_GOOD);
      sentence("$V,360,R,2", SUM_GOOD);
      sentence("$V,179.999,R,0.001", SUM_GOOD);
      send_byte(CH_DOLLAR);
      quiesce();
    end
  endtask

  task automatic test_back_pressure();
    @(posedge clk);
    hold_requests++;
    // short valid sentences pile up behind the stalled receiver
    repeat (14) sentence("$R,3", SUM_GOOD);
    send_byte(CH_DOLLAR);
    quiesce();
  endtask

  task automatic test_random_traffic();
    int kind, n, r, target;
    sum_form_t form;
    string soup;
    soup = "VR,.0123456789-* A";
    for (int p = 0; p < 4; p++) begin
      write_offset((p == 1) ? 8'd255 : (p == 2) ? 8'd0 : 8'($urandom_range(0, 255)));
      target = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < target) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          add_text(($urandom_range(0, 1) == 0) ? "$WIMWV," : "$IIMWV,");
          add_number(3);
          add_text(($urandom_range(0, 4) == 0) ? ",T," : ",R,");
          add_number(4);
          add_text(",N,A");
          r = $urandom_range(0, 19);
          form = (r < 6) ? sum_form_t'(r) : SUM_GOOD;
          add_check(form);
        end else if (kind < 85) begin
          // marker soup inside a sentence
          frame.push_back(CH_DOLLAR);
          n = $urandom_range(1, 16);
          repeat (n) frame.push_back(soup[$urandom_range(0, soup.len() - 1)]);
          add_check(($urandom_range(0, 3) == 0) ? SUM_WRONG : SUM_GOOD);
        end else begin
          n = $urandom_range(1, 12);
          repeat (n) frame.push_back(8'($urandom));
        end
        send_frame();
      end
      send_byte(CH_DOLLAR);
      quiesce();
    end
  endtask

  // receiver: own stall pattern plus one long hold on request
  always @(negedge clk) begin
    rx_tick++;
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else begin
      case (rx_tick[8:7])
        2'd0: out_ready = 1'b1;
        2'd1: out_ready = ($urandom_range(0, 1) == 1);
        2'd2: out_ready = (rx_tick[1:0] == 2'd0);
        default: begin
          out_ready = 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 30);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    wind_reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        note_failure($sformatf("unexpected word dir=%0d spd=%0d", direction_mrad, speed_dmps));
      end else begin
        want = expected_readings.pop_front();
        if (direction_mrad !== want.dir || speed_dmps !== want.spd)
          note_failure($sformatf("word mismatch: dir exp %0d got %0d, spd exp %0d got %0d",
                                 want.dir, direction_mrad, want.spd, speed_dmps));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clear_sentence();
    offset_deg = OFFSET_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_preamble_and_defaults();
    test_checksum_rules();
    test_field_syntax();
    test_offset_extremes();
    test_back_pressure();
    test_random_traffic();
    quiesce();
    if (expected_readings.size() != 0)
      note_failure($sformatf("%0d readings never arrived", expected_readings.size()));
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/nwsp_pkg.sv
src/nwsp_parser.sv
src/nwsp_convert.sv
src/nmea_wind_sentence_parser_top.sv
src/nwsp_checker.sv
tb/tb_nmea_wind_sentence_parser_top.sv
